>>> design/bgv_pkg.sv
// package for the binocular gaze vector unit
// constants, cordic table and controller/datapath command types; no dependencies
package bgv_pkg;

    localparam int AGE_WIDTH   = 16;
    localparam int ANG_W       = 17;
    localparam int VEC_W       = 16;
    localparam int CFG_W       = 16;
    localparam int ITERS       = 16;
    localparam int IT_W        = 4;
    localparam int CX_W        = 32;   // cordic x/y width
    localparam int CZ_W        = 26;   // cordic angle width, 2^-16 degree
    localparam int ACC_W       = 34;   // sum of two q4.28 products

    localparam logic signed [ANG_W-1:0] ANG_LIMIT   = 17'sd46080;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 17'sd23040;
    localparam logic signed [CX_W-1:0]  CORDIC_START = 32'sd163008219;
    localparam logic [CFG_W-1:0]        TIMEOUT_RESET = 16'd1000;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // angle select codes: which of the four angles the cordic works on
    localparam logic [1:0] SEL_LP = 2'd0;
    localparam logic [1:0] SEL_LY = 2'd1;
    localparam logic [1:0] SEL_RP = 2'd2;
    localparam logic [1:0] SEL_RY = 2'd3;

    function automatic logic signed [CZ_W-1:0] atan_tab(input logic [IT_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        unique case (i)
            4'd0:  r = 26'sd2949120;
            4'd1:  r = 26'sd1740967;
            4'd2:  r = 26'sd919879;
            4'd3:  r = 26'sd466945;
            4'd4:  r = 26'sd234379;
            4'd5:  r = 26'sd117304;
            4'd6:  r = 26'sd58666;
            4'd7:  r = 26'sd29335;
            4'd8:  r = 26'sd14668;
            4'd9:  r = 26'sd7334;
            4'd10: r = 26'sd3667;
            4'd11: r = 26'sd1833;
            4'd12: r = 26'sd917;
            4'd13: r = 26'sd458;
            4'd14: r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic       load_in;     // capture input item
        logic       cordic_init; // start cordic on selected angle
        logic [1:0] sel;
        logic       cordic_step;
        logic       store_sc;    // store sin/cos of selected angle
        logic [1:0] mul_phase;   // which product to form
        logic       mul_en;
        logic       commit;      // write the averaged vector, clear age
        logic       tick;        // age the counter
    } bgv_cmd_t;

    typedef struct packed {
        logic           is_tick;
        logic           invalid;
        logic [IT_W-1:0] iter;
    } bgv_status_t;

endpackage

>>> design/bgv_datapath.sv
// datapath: input capture, shared iterative cordic, products, stored vector and age
// depends on bgv_pkg
module bgv_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  bgv_pkg::bgv_cmd_t              cmd,
    output bgv_pkg::bgv_status_t           status,
    input  logic [71:0]                    in_data,
    input  logic                           cfg_we,
    input  logic [bgv_pkg::CFG_W-1:0]      cfg_data,
    output logic                           avail,
    output logic [bgv_pkg::VEC_W-1:0]      gx,
    output logic [bgv_pkg::VEC_W-1:0]      gy,
    output logic [bgv_pkg::VEC_W-1:0]      gz
);
    localparam int AW = bgv_pkg::ANG_W;
    localparam int XW = bgv_pkg::CX_W;
    localparam int ZW = bgv_pkg::CZ_W;
    localparam int VW = bgv_pkg::VEC_W;
    localparam int PW = 32;

    logic [71:0] item_reg;
    logic signed [XW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic neg_reg, neg_next;
    logic [bgv_pkg::IT_W-1:0] it_reg, it_next;
    logic signed [VW-1:0] sp_reg [2], cp_reg [2], sy_reg [2], cy2_reg [2];
    logic signed [bgv_pkg::ACC_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [VW-1:0] gx_reg, gy_reg, gz_reg;
    logic [bgv_pkg::AGE_WIDTH-1:0] age_reg;
    logic [bgv_pkg::CFG_W-1:0] tmo_reg;

    logic signed [AW-1:0] raw, sat, red;
    logic signed [VW-1:0] s_rnd, c_rnd;
    logic signed [VW-1:0] ma, mb;
    logic signed [PW-1:0] prod_next;

    function automatic logic signed [VW-1:0] rnd14(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] m;
        logic signed [XW-1:0] r;
        m = v[XW-1] ? -v : v;
        r = (m + 32'sd8192) >>> 14;
        return v[XW-1] ? -r[VW-1:0] : r[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] rnd15(input logic signed [bgv_pkg::ACC_W-1:0] v);
        logic signed [bgv_pkg::ACC_W-1:0] m;
        logic signed [bgv_pkg::ACC_W-1:0] r;
        m = v[bgv_pkg::ACC_W-1] ? -v : v;
        r = (m + 34'sd16384) >>> 15;
        return v[bgv_pkg::ACC_W-1] ? -r[VW-1:0] : r[VW-1:0];
    endfunction

    // angle pick, saturate, negate pitch, reduce to +-90
    always_comb
    begin
        unique case (cmd.sel)
            bgv_pkg::SEL_LP: raw = item_reg[17:1];
            bgv_pkg::SEL_LY: raw = item_reg[34:18];
            bgv_pkg::SEL_RP: raw = item_reg[51:35];
            default:         raw = item_reg[68:52];
        endcase
        sat = raw;
        if (raw > bgv_pkg::ANG_LIMIT)  sat = bgv_pkg::ANG_LIMIT;
        if (raw < -bgv_pkg::ANG_LIMIT) sat = -bgv_pkg::ANG_LIMIT;
        if (!cmd.sel[0]) sat = -sat;
        neg_next = 1'b0;
        red = sat;
        if (sat > bgv_pkg::ANG_QUARTER)
        begin
            red = sat - bgv_pkg::ANG_LIMIT;
            neg_next = 1'b1;
        end
        else if (sat < -bgv_pkg::ANG_QUARTER)
        begin
            red = sat + bgv_pkg::ANG_LIMIT;
            neg_next = 1'b1;
        end
    end

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        it_next = it_reg;
        if (cmd.cordic_init)
        begin
            cx_next = bgv_pkg::CORDIC_START;
            cy_next = '0;
            cz_next = ZW'(red) <<< 8;
            it_next = '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!cz_reg[ZW-1])
            begin
                cx_next = cx_reg - (cy_reg >>> it_reg);
                cy_next = cy_reg + (cx_reg >>> it_reg);
                cz_next = cz_reg - bgv_pkg::atan_tab(it_reg);
            end
            else
            begin
                cx_next = cx_reg + (cy_reg >>> it_reg);
                cy_next = cy_reg - (cx_reg >>> it_reg);
                cz_next = cz_reg + bgv_pkg::atan_tab(it_reg);
            end
            it_next = it_reg + 1'b1;
        end
        s_rnd = neg_reg ? -rnd14(cy_reg) : rnd14(cy_reg);
        c_rnd = neg_reg ? -rnd14(cx_reg) : rnd14(cx_reg);
    end

    // product phases: 0 x left, 1 x right, 2 z left, 3 z right
    always_comb
    begin
        unique case (cmd.mul_phase)
            2'd0: begin ma = sy_reg[0];  mb = cp_reg[0]; end
            2'd1: begin ma = sy_reg[1];  mb = cp_reg[1]; end
            2'd2: begin ma = cy2_reg[0]; mb = cp_reg[0]; end
            default: begin ma = cy2_reg[1]; mb = cp_reg[1]; end
        endcase
        prod_next = PW'(ma) * PW'(mb);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in) item_reg <= in_data;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        it_reg <= it_next;
        if (cmd.cordic_init) neg_reg <= neg_next;
        if (cmd.store_sc)
        begin
            unique case (cmd.sel)
                bgv_pkg::SEL_LP: begin sp_reg[0] <= s_rnd; cp_reg[0] <= c_rnd; end
                bgv_pkg::SEL_LY: begin sy_reg[0] <= s_rnd; cy2_reg[0] <= c_rnd; end
                bgv_pkg::SEL_RP: begin sp_reg[1] <= s_rnd; cp_reg[1] <= c_rnd; end
                default:         begin sy_reg[1] <= s_rnd; cy2_reg[1] <= c_rnd; end
            endcase
        end
        if (cmd.mul_en) prod_reg <= prod_next;
        // accumulate the product registered in the previous cycle
        if (cmd.cordic_init && cmd.sel == bgv_pkg::SEL_LP)
        begin
            ax_reg <= '0;
            az_reg <= '0;
        end
        if (cmd.store_sc && cmd.sel == bgv_pkg::SEL_RY)
            ay_reg <= ($signed({{(bgv_pkg::ACC_W-VW){sp_reg[0][VW-1]}}, sp_reg[0]})
                      + $signed({{(bgv_pkg::ACC_W-VW){sp_reg[1][VW-1]}}, sp_reg[1]})) <<< 14;
        if (cmd.tick && cmd.mul_phase[0] == 1'b0)
        begin
            // accumulate slot: tick field reused as "add prod" strobe
            if (!cmd.mul_phase[1]) ax_reg <= ax_reg + bgv_pkg::ACC_W'(prod_reg);
            else                   az_reg <= az_reg - bgv_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg  <= '0;
            gy_reg  <= '0;
            gz_reg  <= '0;
            age_reg <= '1;
            tmo_reg <= bgv_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_we) tmo_reg <= cfg_data;
            if (cmd.commit)
            begin
                gx_reg  <= rnd15(ax_reg);
                gy_reg  <= rnd15(ay_reg);
                gz_reg  <= rnd15(az_reg);
                age_reg <= '0;
            end
            else if (cmd.tick && cmd.mul_phase == 2'd1 && age_reg != '1)
                age_reg <= age_reg + 1'b1;
        end
    end

    assign status.is_tick = item_reg[0];
    assign status.invalid = item_reg[69];
    assign status.iter    = it_reg;
    assign avail = ({{(32-bgv_pkg::AGE_WIDTH){1'b0}}, age_reg}
                    < {{(32-bgv_pkg::CFG_W){1'b0}}, tmo_reg});
    assign gx = gx_reg;
    assign gy = gy_reg;
    assign gz = gz_reg;
endmodule

>>> design/bgv_ctrl.sv
// controller: sequences cordic runs, products and the result handshake
// depends on bgv_pkg
module bgv_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bgv_pkg::bgv_cmd_t     cmd,
    input  bgv_pkg::bgv_status_t  status
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_INIT = 4'd2;
    localparam logic [3:0] S_ROT  = 4'd3;
    localparam logic [3:0] S_SC   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_COM  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] ph_reg, ph_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ph_next    = ph_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.mul_phase = ph_reg;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_fire;
                if (in_fire) state_next = S_DEC;
            end
            S_DEC:
            begin
                if (status.is_tick)
                begin
                    cmd.tick = 1'b1;
                    cmd.mul_phase = 2'd1;
                    state_next = S_OUT;
                end
                else if (status.invalid) state_next = S_OUT;
                else
                begin
                    sel_next = bgv_pkg::SEL_LP;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.cordic_init = 1'b1;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.cordic_step = 1'b1;
                if (status.iter == bgv_pkg::IT_W'(bgv_pkg::ITERS - 1)) state_next = S_SC;
            end
            S_SC:
            begin
                cmd.store_sc = 1'b1;
                sel_next = sel_reg + 2'd1;
                if (sel_reg == bgv_pkg::SEL_RY)
                begin
                    ph_next = 2'd0;
                    state_next = S_MUL;
                end
                else state_next = S_INIT;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // add strobe with even phase code: 0 adds to x, 2 subtracts into z
                cmd.tick = 1'b1;
                cmd.mul_phase = {ph_reg[1], 1'b0};
                ph_next = ph_reg + 2'd1;
                state_next = (ph_reg == 2'd3) ? S_COM : S_MUL;
            end
            S_COM:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            ph_reg    <= ph_next;
        end
    end
endmodule

>>> design/binocular_gaze_vector_unit.sv
// top level of the binocular gaze vector unit
// depends on bgv_pkg, bgv_ctrl, bgv_datapath
//
// usage:
//   s_axis carries one item per transfer: an eye sample (four q9.8 angles)
//   or a time tick, chosen by s_axis_tuser. every accepted item yields exactly
//   one m_axis transfer with the stored q2.14 gaze vector and the available flag
//   (set while the sample age is below timeout_ticks).
//   a tick or an invalid sample gives its result straight after decode; a valid
//   sample first runs through one shared cordic, 16 rotations for each of the four
//   angles, then four products through a single multiplier.
//   one item at a time: s_axis_tready is high only while idle, so the next
//   item is taken only after the current result has been sent.
//   stall: the result holds on m_axis until m_axis_tready; no new item is
//   taken meanwhile.
//   reset: vector cleared, age all ones (gaze unavailable), timeout 1000.
//   cfg_we writes timeout_ticks; do it only while idle.
module binocular_gaze_vector_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: left_pitch_deg[16:0], left_yaw_deg[33:17], right_pitch_deg[50:34],
    //        right_yaw_deg[67:51], angles_invalid[68], zero pad
    input  logic [71:0] s_axis_tdata,
    // tuser: req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: gaze_available[0], gaze_x[16:1], gaze_y[32:17], gaze_z[48:33], zero pad
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);
    bgv_pkg::bgv_cmd_t    cmd;
    bgv_pkg::bgv_status_t status;
    logic        in_fire;
    logic        avail;
    logic [15:0] gx, gy, gz;
    logic [71:0] item;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    // internal item layout: req_type in bit 0, tdata fields above
    assign item = {s_axis_tdata[70:0], s_axis_tuser};

    bgv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    bgv_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .avail    (avail),
        .gx       (gx),
        .gy       (gy),
        .gz       (gz)
    );

    assign m_axis_tdata = {7'd0, gz, gy, gx, avail};
endmodule

>>> design/bgv_checker.sv
// port-level checker for the binocular gaze vector unit, bound to the top level
// depends on binocular_gaze_vector_unit ports only
module bgv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_no_accept_while_result:
        assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_result_holds:
        assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

    a_accept_busy:
        assert property (@(posedge clk) disable iff (!rst_n)
            s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while busy");

    a_pad_zero:
        assert property (@(posedge clk) disable iff (!rst_n)
            m_axis_tvalid |-> m_axis_tdata[55:49] == 7'd0)
        else $error("pad bits set");
endmodule

bind binocular_gaze_vector_unit bgv_checker u_bgv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
